// ----- rtl/rarp_pkg.sv -----
// Shared types and constants of the array request parser.
`timescale 1ns / 1ps

package rarp_pkg;

   // Bounds on the announced part count and bulk string length.
   localparam int unsigned MAX_PARTS       = 16;
   localparam int unsigned MAX_BULK_LENGTH = 65535;

   // Field widths of the result item.
   localparam int unsigned EVENT_W  = 3;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned INDEX_W  = 4;
   localparam int unsigned COUNT_W  = 5;
   localparam int unsigned LENGTH_W = 16;

   // Decimal accumulator: holds the larger bound; one digit step widens it by four bits.
   localparam int unsigned ACCUM_W = $clog2(MAX_BULK_LENGTH + 1);
   localparam int unsigned STEP_W  = ACCUM_W + 4;

   // Framing characters.
   localparam logic [BYTE_W-1:0] CHAR_STAR   = 8'h2A;
   localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;

   typedef enum logic [3:0] {
      PH_WAIT      = 4'd0,
      PH_CNT_FIRST = 4'd1,
      PH_CNT_MORE  = 4'd2,
      PH_CNT_LF    = 4'd3,
      PH_DOLLAR    = 4'd4,
      PH_LEN_FIRST = 4'd5,
      PH_LEN_MORE  = 4'd6,
      PH_LEN_LF    = 4'd7,
      PH_DATA      = 4'd8,
      PH_TRAIL1    = 4'd9,
      PH_TRAIL2    = 4'd10
   } phase_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_FRAME   = 3'd0,
      EV_PAYLOAD = 3'd1,
      EV_PART    = 3'd2,
      EV_DONE    = 3'd3,
      EV_BAD     = 3'd4
   } event_type;

   typedef struct packed {
      event_type           event_kind;
      logic [BYTE_W-1:0]   payload_byte;
      logic [INDEX_W-1:0]  part_index;
      logic [COUNT_W-1:0]  part_count;
      logic [LENGTH_W-1:0] part_length;
   } result_type;

endpackage

// ----- rtl/rarp_parser.sv -----
// Parse state registers and the per-byte next-state and result logic.
`timescale 1ns / 1ps

module rarp_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          byte_accept,
   input  logic [rarp_pkg::BYTE_W-1:0]   rx_byte,
   output rarp_pkg::result_type          result
);
   import rarp_pkg::*;

   phase_type             phase_ff,  phase_in;
   logic [ACCUM_W-1:0]    accum_ff,  accum_in;
   logic [COUNT_W-1:0]    total_ff,  total_in;
   logic [INDEX_W-1:0]    part_ff,   part_in;
   logic [LENGTH_W-1:0]   left_ff,   left_in;
   logic [LENGTH_W-1:0]   length_ff, length_in;

   logic                  bad;
   logic                  is_digit;
   logic [STEP_W-1:0]     step_sum;
   logic [STEP_W-1:0]     step_limit;
   logic                  over_limit;
   logic                  last_part;

   assign is_digit   = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   // accum * 10 + digit, as two shifted adds
   assign step_sum   = {1'b0, accum_ff, 3'b000} + {2'b00, accum_ff, 1'b0}
                     + {{(STEP_W-4){1'b0}}, rx_byte[3:0]};
   assign step_limit = ((phase_ff == PH_CNT_FIRST) || (phase_ff == PH_CNT_MORE))
                     ? STEP_W'(MAX_PARTS) : STEP_W'(MAX_BULK_LENGTH);
   assign over_limit = step_sum > step_limit;
   assign last_part  = ({1'b0, part_ff} + COUNT_W'(1)) >= total_ff;

   // Next state
   always_comb begin
      phase_in  = phase_ff;
      accum_in  = accum_ff;
      total_in  = total_ff;
      part_in   = part_ff;
      left_in   = left_ff;
      length_in = length_ff;
      bad       = 1'b0;
      unique case (phase_ff)
         PH_WAIT: begin
            if (rx_byte == CHAR_STAR) begin
               accum_in  = '0;
               total_in  = '0;
               part_in   = '0;
               left_in   = '0;
               length_in = '0;
               phase_in  = PH_CNT_FIRST;
            end else begin
               bad = 1'b1;
            end
         end
         PH_CNT_FIRST, PH_CNT_MORE, PH_LEN_FIRST, PH_LEN_MORE: begin
            if (is_digit) begin
               if (over_limit) begin
                  bad = 1'b1;
               end else begin
                  accum_in = step_sum[ACCUM_W-1:0];
                  phase_in = ((phase_ff == PH_CNT_FIRST) || (phase_ff == PH_CNT_MORE))
                           ? PH_CNT_MORE : PH_LEN_MORE;
               end
            end else if (rx_byte == CHAR_CR && phase_ff == PH_CNT_MORE) begin
               phase_in = PH_CNT_LF;
            end else if (rx_byte == CHAR_CR && phase_ff == PH_LEN_MORE) begin
               phase_in = PH_LEN_LF;
            end else begin
               bad = 1'b1;
            end
         end
         PH_CNT_LF: begin
            if (rx_byte == CHAR_LF) begin
               total_in = accum_ff[COUNT_W-1:0];
               accum_in = '0;
               part_in  = '0;
               phase_in = (accum_ff == '0) ? PH_WAIT : PH_DOLLAR;
            end else begin
               bad = 1'b1;
            end
         end
         PH_DOLLAR: begin
            if (rx_byte == CHAR_DOLLAR) begin
               accum_in  = '0;
               length_in = '0;
               phase_in  = PH_LEN_FIRST;
            end else begin
               bad = 1'b1;
            end
         end
         PH_LEN_LF: begin
            if (rx_byte == CHAR_LF) begin
               length_in = accum_ff[LENGTH_W-1:0];
               left_in   = accum_ff[LENGTH_W-1:0];
               accum_in  = '0;
               phase_in  = (accum_ff != '0) ? PH_DATA : PH_TRAIL1;
            end else begin
               bad = 1'b1;
            end
         end
         PH_DATA: begin
            if (left_ff > LENGTH_W'(1)) begin
               left_in = left_ff - LENGTH_W'(1);
            end else begin
               left_in  = '0;
               phase_in = PH_TRAIL1;
            end
         end
         PH_TRAIL1: begin
            phase_in = PH_TRAIL2;
         end
         PH_TRAIL2: begin
            if (last_part) begin
               phase_in = PH_WAIT;
            end else begin
               part_in  = part_ff + INDEX_W'(1);
               phase_in = PH_DOLLAR;
            end
         end
         default: begin
            bad = 1'b1;
         end
      endcase
      if (bad) begin
         accum_in = '0;
         phase_in = PH_WAIT;
      end
   end

   // Result for the byte at hand
   always_comb begin
      result.event_kind   = EV_FRAME;
      result.payload_byte = '0;
      result.part_index   = part_in;
      result.part_count   = total_in;
      result.part_length  = length_in;
      if (bad) begin
         result.event_kind = EV_BAD;
      end else begin
         unique case (phase_ff)
            PH_CNT_LF: begin
               if (accum_ff == '0) begin
                  result.event_kind = EV_DONE;
               end
            end
            PH_DATA: begin
               result.event_kind   = EV_PAYLOAD;
               result.payload_byte = rx_byte;
            end
            PH_TRAIL2: begin
               result.event_kind = last_part ? EV_DONE : EV_PART;
               result.part_index = part_ff;
            end
            default: begin
               result.event_kind = EV_FRAME;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         accum_ff  <= '0;
         total_ff  <= '0;
         part_ff   <= '0;
         left_ff   <= '0;
         length_ff <= '0;
      end else if (byte_accept) begin
         phase_ff  <= phase_in;
         accum_ff  <= accum_in;
         total_ff  <= total_in;
         part_ff   <= part_in;
         left_ff   <= left_in;
         length_ff <= length_in;
      end
   end

endmodule

// ----- rtl/rarp_out_queue.sv -----
// Two-entry result queue that decouples the result channel from the parser.
`timescale 1ns / 1ps

module rarp_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rarp_pkg::result_type push_data,
   output logic                 not_full,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output rarp_pkg::result_type pop_data
);
   import rarp_pkg::*;

   result_type  slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff,  count_in;
   logic        pop;

   assign not_full  = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/resp_array_request_parser.sv -----
// Top level of the byte-serial array-of-bulk-strings request parser.
`timescale 1ns / 1ps

// Takes one request byte per item and returns one result item per byte that
// tags it as framing, payload, end of a part, end of the request or
// malformed, along with the part index, announced part count and announced
// length. Throughput is one byte per clock while the queue has room: the parse
// state updates and the combinational result enters a two-entry output queue
// at the same clock edge that accepts the byte. req_ready drops only when both
// queue entries hold results not yet taken, so the queue depth alone sets when
// input stalls. After a malformed byte or a completed request the parser drops
// bytes as malformed until the next '*'. Counts above 16 and lengths above
// 65535 are rejected on the digit that crosses the bound.
module resp_array_request_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rarp_pkg::BYTE_W-1:0]     req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rarp_pkg::EVENT_W-1:0]    rsp_event_kind,
   output logic [rarp_pkg::BYTE_W-1:0]     rsp_payload_byte,
   output logic [rarp_pkg::INDEX_W-1:0]    rsp_part_index,
   output logic [rarp_pkg::COUNT_W-1:0]    rsp_part_count,
   output logic [rarp_pkg::LENGTH_W-1:0]   rsp_part_length
);
   import rarp_pkg::*;

   logic       byte_accept;
   result_type parsed;
   result_type queued;

   // Advance the parser on every accepted byte.
   assign byte_accept = req_valid && req_ready;

   rarp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_rx_byte),
      .result      (parsed)
   );

   // Hold results here while the consumer stalls.
   rarp_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (byte_accept),
      .push_data (parsed),
      .not_full  (req_ready),
      .pop_valid (rsp_valid),
      .pop_ready (rsp_ready),
      .pop_data  (queued)
   );

   assign rsp_event_kind   = queued.event_kind;
   assign rsp_payload_byte = queued.payload_byte;
   assign rsp_part_index   = queued.part_index;
   assign rsp_part_count   = queued.part_count;
   assign rsp_part_length  = queued.part_length;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the array-of-bulk-strings request parser.
`timescale 1ns / 1ps

module testbench;
   import rarp_pkg::*;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_rx_byte = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   logic [EVENT_W-1:0]  rsp_event_kind;
   logic [BYTE_W-1:0]   rsp_payload_byte;
   logic [INDEX_W-1:0]  rsp_part_index;
   logic [COUNT_W-1:0]  rsp_part_count;
   logic [LENGTH_W-1:0] rsp_part_length;

   resp_array_request_parser uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_part_index   (rsp_part_index),
      .rsp_part_count   (rsp_part_count),
      .rsp_part_length  (rsp_part_length)
   );

   always #1 clock = ~clock;

   // Parser state as the predictor tracks it, updated once per accepted byte.
   phase_type   rx_phase         = PH_WAIT;
   int unsigned digits_value     = 0;
   int unsigned announced_parts  = 0;
   int unsigned part_now         = 0;
   int unsigned payload_left     = 0;
   int unsigned announced_length = 0;

   result_type        expected_results[$];  // predicted results, oldest first
   logic [BYTE_W-1:0] frame[$];             // request bytes being assembled
   int                failures      = 0;
   int                bytes_sent    = 0;
   int unsigned       send_idle_pct = 0;
   int unsigned       recv_idle_pct = 0;

   function automatic logic is_digit(input logic [BYTE_W-1:0] b);
      return b >= CHAR_ZERO && b <= CHAR_NINE;
   endfunction

   // Advance the predicted parser by one byte and return the result it yields.
   function automatic result_type predict_result(input logic [BYTE_W-1:0] b);
      result_type  r;
      logic        bad;
      logic        ended;
      int unsigned ended_idx;
      int unsigned grown;
      r         = '0;
      bad       = 1'b0;
      ended     = 1'b0;
      ended_idx = 0;
      // Only meaningful when b is a digit.
      grown     = digits_value * 10 + (b - CHAR_ZERO);
      case (rx_phase)
         PH_WAIT: begin
            if (b == CHAR_STAR) begin
               // A new request clears every counter.
               digits_value     = 0;
               announced_parts  = 0;
               part_now         = 0;
               payload_left     = 0;
               announced_length = 0;
               rx_phase         = PH_CNT_FIRST;
            end else begin
               bad = 1'b1;
            end
         end
         PH_CNT_FIRST, PH_CNT_MORE: begin
            if (is_digit(b) && grown <= MAX_PARTS) begin
               digits_value = grown;
               rx_phase     = PH_CNT_MORE;
            end else if (b == CHAR_CR && rx_phase == PH_CNT_MORE) begin
               rx_phase = PH_CNT_LF;
            end else begin
               bad = 1'b1;
            end
         end
         PH_CNT_LF: begin
            if (b == CHAR_LF) begin
               announced_parts = digits_value;
               digits_value    = 0;
               part_now        = 0;
               if (announced_parts == 0) begin
                  r.event_kind = EV_DONE;
                  rx_phase     = PH_WAIT;
               end else begin
                  rx_phase = PH_DOLLAR;
               end
            end else begin
               bad = 1'b1;
            end
         end
         PH_DOLLAR: begin
            if (b == CHAR_DOLLAR) begin
               digits_value     = 0;
               announced_length = 0;
               rx_phase         = PH_LEN_FIRST;
            end else begin
               bad = 1'b1;
            end
         end
         PH_LEN_FIRST, PH_LEN_MORE: begin
            if (is_digit(b) && grown <= MAX_BULK_LENGTH) begin
               digits_value = grown;
               rx_phase     = PH_LEN_MORE;
            end else if (b == CHAR_CR && rx_phase == PH_LEN_MORE) begin
               rx_phase = PH_LEN_LF;
            end else begin
               bad = 1'b1;
            end
         end
         PH_LEN_LF: begin
            if (b == CHAR_LF) begin
               announced_length = digits_value;
               digits_value     = 0;
               payload_left     = announced_length;
               rx_phase         = (payload_left != 0) ? PH_DATA : PH_TRAIL1;
            end else begin
               bad = 1'b1;
            end
         end
         PH_DATA: begin
            r.event_kind   = EV_PAYLOAD;
            r.payload_byte = b;
            if (payload_left != 0) payload_left--;
            if (payload_left == 0) rx_phase = PH_TRAIL1;
         end
         PH_TRAIL1: begin
            rx_phase = PH_TRAIL2;
         end
         PH_TRAIL2: begin
            // The part-ending byte reports the index of the part that ended.
            ended     = 1'b1;
            ended_idx = part_now;
            if (part_now + 1 >= announced_parts) begin
               r.event_kind = EV_DONE;
               rx_phase     = PH_WAIT;
            end else begin
               r.event_kind = EV_PART;
               part_now++;
               rx_phase = PH_DOLLAR;
            end
         end
         default: begin
            bad = 1'b1;
         end
      endcase
      if (bad) begin
         // Context fields keep their values; drop back to hunting for '*'.
         r.event_kind   = EV_BAD;
         r.payload_byte = '0;
         digits_value   = 0;
         rx_phase       = PH_WAIT;
      end
      r.part_index  = ended ? ended_idx[INDEX_W-1:0] : part_now[INDEX_W-1:0];
      r.part_count  = announced_parts[COUNT_W-1:0];
      r.part_length = announced_length[LENGTH_W-1:0];
      return r;
   endfunction

   // Send one request byte: idle at random first, then hold valid until accepted.
   // Valid stays high after acceptance so back-to-back bytes need no toggle.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(predict_result(b));
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_frame();
      foreach (frame[i]) send_byte(frame[i]);
   endtask

   // Hold off the sender until every predicted result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // Append a decimal number, now and then with leading zeros.
   task automatic append_number(input int unsigned n);
      string s;
      s = $sformatf("%0d", n);
      if ($urandom_range(7) == 0) repeat ($urandom_range(2, 1)) frame.push_back(CHAR_ZERO);
      for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
   endtask

   // Append one bulk string: header, random payload, unchecked trailer.
   task automatic append_part(input int unsigned len);
      frame.push_back(CHAR_DOLLAR);
      append_number(len);
      frame.push_back(CHAR_CR);
      frame.push_back(CHAR_LF);
      repeat (len) frame.push_back(BYTE_W'($urandom_range(255)));
      if ($urandom_range(1) == 0) begin
         frame.push_back(CHAR_CR);
         frame.push_back(CHAR_LF);
      end else begin
         repeat (2) frame.push_back(BYTE_W'($urandom_range(255)));
      end
   endtask

   task automatic start_request(input int unsigned parts);
      frame.delete();
      frame.push_back(CHAR_STAR);
      append_number(parts);
      frame.push_back(CHAR_CR);
      frame.push_back(CHAR_LF);
   endtask

   function automatic logic [BYTE_W-1:0] tricky_byte();
      case ($urandom_range(5))
         0:       return CHAR_STAR;
         1:       return CHAR_DOLLAR;
         2:       return CHAR_CR;
         3:       return CHAR_LF;
         4:       return CHAR_ZERO - 1;  // just below the digits
         default: return CHAR_NINE + 1;  // just above the digits
      endcase
   endfunction

   // Well-formed request with random content, damaged one time in four.
   task automatic build_request();
      int unsigned parts;
      int unsigned k;
      parts = ($urandom_range(9) == 0) ? $urandom_range(MAX_PARTS) : $urandom_range(3, 1);
      start_request(parts);
      repeat (parts) append_part(($urandom_range(9) == 0) ? $urandom_range(40)
                                                           : $urandom_range(6));
      if ($urandom_range(3) != 0) return;
      k = $urandom_range(frame.size() - 1);
      case ($urandom_range(4))
         0: frame[k] = BYTE_W'($urandom_range(255));
         1: frame[k] = tricky_byte();
         2: frame = frame[0:k];  // truncate mid-request
         3: repeat ($urandom_range(3, 1)) frame.push_front(BYTE_W'($urandom_range(255)));
         default: begin
            // Count or length past its bound.
            if ($urandom_range(1) == 0) begin
               start_request($urandom_range(999, MAX_PARTS + 1));
            end else begin
               start_request(1);
               frame.push_back(CHAR_DOLLAR);
               append_number($urandom_range(999999, MAX_BULK_LENGTH + 1));
               frame.push_back(CHAR_CR);
               frame.push_back(CHAR_LF);
            end
         end
      endcase
   endtask

   // Bytes other than '*' while hunting for a request.
   task automatic test_outside_bytes();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CHAR_DOLLAR);
      send_byte(CHAR_CR);
      wait_drained();
   endtask

   // Array header cases; \015\012 is CR LF.
   task automatic test_count_header();
      send_text("*0\015\012");    // zero parts completes at once
      send_text("*000\015\012");  // leading zeros
      send_text("*\015");         // empty count
      send_text("*-1");           // sign, then a stray digit outside a request
      send_text("*1\015$");       // CR not followed by LF
      send_text("*17");           // one past the part bound
      send_text("*2\015\012#");   // wrong part marker
      wait_drained();
   endtask

   task automatic test_length_header();
      send_text("*1\015\012$\015");      // empty length
      send_text("*1\015\012$65536");     // one past the length bound
      send_text("*1\015\012$7 ");        // space inside a number
      wait_drained();
   endtask

   // Zero-length part runs straight into its trailer.
   task automatic test_zero_length();
      send_text("*2\015\012$0\015\012\015\012$1\015\012Z\015\012");
      wait_drained();
   endtask

   task automatic test_max_parts();
      start_request(MAX_PARTS);
      for (int p = 0; p < MAX_PARTS; p++) append_part(p % 3);
      send_frame();
      wait_drained();
   endtask

   // Largest length passes its bound check; a digit in place of the LF then drops it.
   task automatic test_max_length();
      start_request(1);
      frame.push_back(CHAR_DOLLAR);
      append_number(MAX_BULK_LENGTH);
      frame.push_back(CHAR_CR);
      frame.push_back(CHAR_ZERO);
      send_frame();
      wait_drained();
   endtask

   task automatic test_random_requests(input int count);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < count) begin
         build_request();
         send_frame();
      end
      // Flush any half-finished request so the next test starts from idle.
      while (rx_phase != PH_WAIT) send_byte('0);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // Compare each result taken against the oldest prediction.
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result with no byte pending: event_kind %0d", rsp_event_kind);
            failures++;
         end else begin
            want = expected_results.pop_front();
            check_field("event_kind", want.event_kind, rsp_event_kind);
            check_field("payload_byte", want.payload_byte, rsp_payload_byte);
            check_field("part_index", want.part_index, rsp_part_index);
            check_field("part_count", want.part_count, rsp_part_count);
            check_field("part_length", want.part_length, rsp_part_length);
         end
      end
   end

   // Receiver stalls at random at the current rate.
   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   initial begin
      send_idle_pct = 26;
      recv_idle_pct = 85;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_outside_bytes();
      test_count_header();
      test_length_header();
      test_zero_length();
      test_max_parts();
      test_random_requests(70);

      // Swap the stall pattern: sender slow, receiver mostly ready.
      send_idle_pct = 85;
      recv_idle_pct = 26;
      test_random_requests(70);

      // Full rate on both sides; the largest length is checked here.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_max_length();
      test_random_requests(70);

      wait_drained();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Guard against a hang.
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- resp_array_request_parser.f -----
rtl/rarp_pkg.sv
rtl/rarp_parser.sv
rtl/rarp_out_queue.sv
rtl/resp_array_request_parser.sv
dv/testbench.sv
